>>> design/mmq_pkg.sv
// Shared constants, types and codes for the two-stack min/max queue.
package mmq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int PORT_W     = 32;
   localparam int AW         = $clog2(DEPTH);
   localparam int CW         = $clog2(DEPTH + 1);
   localparam int COUNT_W    = 7;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [AW-1:0]                addr_type;
   typedef logic [CW-1:0]                depth_type;

   typedef struct packed {
      data_type value;
      data_type rmax;
      data_type rmin;
   } entry_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic {
      FN_PUSH = 1'b0,
      FN_POP  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_XFER_RD,
      S_XFER_WR,
      S_POP_RD,
      S_POP_VAL,
      S_POP_TOP,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic       start;
      logic       push;
      logic       xfer_rd;
      logic       xfer_wr;
      logic       pop_rd;
      logic       pop_val;
      logic       pop_top;
      logic       report;
      status_type status;
   } ctl_type;

endpackage

>>> design/mmq_stack.sv
// Stack storage: one write port, one read port with registered read data.
module mmq_stack (
   input  logic               clock,
   input  logic               wr_en,
   input  mmq_pkg::addr_type  wr_addr,
   input  mmq_pkg::entry_type wr_data,
   input  mmq_pkg::addr_type  rd_addr,
   output mmq_pkg::entry_type rd_data
);
   import mmq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mmq_minmax.sv
// Shared min/max unit: merges two (min, max) pairs.
module mmq_minmax (
   input  mmq_pkg::data_type a_min,
   input  mmq_pkg::data_type a_max,
   input  mmq_pkg::data_type b_min,
   input  mmq_pkg::data_type b_max,
   output mmq_pkg::data_type y_min,
   output mmq_pkg::data_type y_max
);
   import mmq_pkg::*;

   assign y_min = (a_min < b_min) ? a_min : b_min;
   assign y_max = (a_max > b_max) ? a_max : b_max;

endmodule

>>> design/mmq_seq.sv
// Sequencer: operation state machine and stack depth counters.
module mmq_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_func,
   input  logic               rsp_free,
   output logic               req_stall,
   output mmq_pkg::ctl_type   ctl,
   output mmq_pkg::depth_type in_depth,
   output mmq_pkg::depth_type out_depth
);
   import mmq_pkg::*;

   state_type state_ff, state_in;
   depth_type in_depth_ff, in_depth_in;
   depth_type out_depth_ff, out_depth_in;
   logic [CW:0] total;
   logic        full;
   logic        empty;

   assign total = {1'b0, in_depth_ff} + {1'b0, out_depth_ff};
   assign full  = (total >= (CW+1)'(DEPTH));
   assign empty = (in_depth_ff == '0) && (out_depth_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_depth_ff  <= '0;
         out_depth_ff <= '0;
      end else begin
         state_ff     <= state_in;
         in_depth_ff  <= in_depth_in;
         out_depth_ff <= out_depth_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      in_depth_in  = in_depth_ff;
      out_depth_in = out_depth_ff;
      ctl          = '0;
      ctl.status   = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.start = 1'b1;
               if (func_type'(req_func) == FN_PUSH) begin
                  if (full) begin
                     ctl.status = ST_OVERFLOW;
                     state_in   = S_REPORT;
                  end else begin
                     state_in = S_PUSH;
                  end
               end else if (empty) begin
                  ctl.status = ST_UNDERFLOW;
                  state_in   = S_REPORT;
               end else if (out_depth_ff == '0) begin
                  state_in = S_XFER_RD;
               end else begin
                  state_in = S_POP_RD;
               end
            end
         end
         S_PUSH: begin
            ctl.push    = 1'b1;
            in_depth_in = in_depth_ff + CW'(1);
            state_in    = S_REPORT;
         end
         S_XFER_RD: begin
            ctl.xfer_rd = 1'b1;
            in_depth_in = in_depth_ff - CW'(1);
            state_in    = S_XFER_WR;
         end
         S_XFER_WR: begin
            ctl.xfer_wr  = 1'b1;
            out_depth_in = out_depth_ff + CW'(1);
            state_in     = (in_depth_ff == '0) ? S_POP_RD : S_XFER_RD;
         end
         S_POP_RD: begin
            ctl.pop_rd   = 1'b1;
            out_depth_in = out_depth_ff - CW'(1);
            state_in     = S_POP_VAL;
         end
         S_POP_VAL: begin
            ctl.pop_val = 1'b1;
            state_in    = (out_depth_ff == '0) ? S_REPORT : S_POP_TOP;
         end
         S_POP_TOP: begin
            ctl.pop_top = 1'b1;
            state_in    = S_REPORT;
         end
         S_REPORT: begin
            ctl.report = 1'b1;
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign in_depth  = in_depth_ff;
   assign out_depth = out_depth_ff;

endmodule

>>> design/min_max_queue_two_stacks.sv
// A push writes the input stack, then reports. A pop, after moving each element
// over by a read and a write if the output stack is empty, reads the value and
// any new top's extremes, and reports; a dropped push or empty pop just reports.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is registered. The single read port of each stack sets the move rate.
// Reset clears the sequencer, both stack depths and the result valid only.
module min_max_queue_two_stacks (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_popped_value,
   output logic signed [31:0] rsp_queue_min,
   output logic signed [31:0] rsp_queue_max,
   output logic [6:0]  rsp_item_count,
   output logic [1:0]  rsp_status
);
   import mmq_pkg::*;

   ctl_type   ctl;
   depth_type in_depth, out_depth;
   logic      rsp_free;

   data_type   value_ff, popped_ff;
   status_type status_ff;
   data_type   in_min_ff, in_max_ff, out_min_ff, out_max_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [PORT_W-1:0] rsp_popped_ff, rsp_min_ff, rsp_max_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   status_type         rsp_status_ff;

   entry_type in_wr_data, out_wr_data, in_rd_data, out_rd_data;
   addr_type  in_rd_addr, out_rd_addr;
   data_type  a_min, a_max, b_min, b_max, u_min, u_max;
   data_type  elem;
   logic      q_empty;
   logic [CW:0] total;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   mmq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .rsp_free  (rsp_free),
      .req_stall (req_stall),
      .ctl       (ctl),
      .in_depth  (in_depth),
      .out_depth (out_depth)
   );

   assign in_rd_addr  = AW'(in_depth - CW'(1));
   assign out_rd_addr = AW'(out_depth - CW'(1));
   assign elem        = in_rd_data.value;
   assign in_wr_data  = '{value: value_ff, rmax: u_max, rmin: u_min};
   assign out_wr_data = '{value: elem, rmax: u_max, rmin: u_min};

   mmq_stack u_in_stack (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (in_depth[AW-1:0]),
      .wr_data (in_wr_data),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   mmq_stack u_out_stack (
      .clock   (clock),
      .wr_en   (ctl.xfer_wr),
      .wr_addr (out_depth[AW-1:0]),
      .wr_data (out_wr_data),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   // Route operands of the shared min/max unit by sequencer step.
   always_comb begin
      a_min = in_min_ff;
      a_max = in_max_ff;
      b_min = out_min_ff;
      b_max = out_max_ff;
      priority if (ctl.push) begin
         a_min = value_ff;
         a_max = value_ff;
         if (in_depth == '0) begin
            b_min = value_ff;
            b_max = value_ff;
         end else begin
            b_min = in_min_ff;
            b_max = in_max_ff;
         end
      end else if (ctl.xfer_wr) begin
         a_min = elem;
         a_max = elem;
         if (out_depth == '0) begin
            b_min = elem;
            b_max = elem;
         end
      end else if (in_depth == '0) begin
         a_min = out_min_ff;
         a_max = out_max_ff;
      end else if (out_depth == '0) begin
         b_min = in_min_ff;
         b_max = in_max_ff;
      end
   end

   mmq_minmax u_minmax (
      .a_min (a_min),
      .a_max (a_max),
      .b_min (b_min),
      .b_max (b_max),
      .y_min (u_min),
      .y_max (u_max)
   );

   assign q_empty = (in_depth == '0) && (out_depth == '0);
   assign total   = {1'b0, in_depth} + {1'b0, out_depth};

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         value_ff  <= req_value[DATA_WIDTH-1:0];
         status_ff <= ctl.status;
         popped_ff <= '0;
      end
      if (ctl.push) begin
         in_min_ff <= u_min;
         in_max_ff <= u_max;
      end
      if (ctl.xfer_wr) begin
         out_min_ff <= u_min;
         out_max_ff <= u_max;
      end
      if (ctl.pop_val) begin
         popped_ff <= out_rd_data.value;
      end
      if (ctl.pop_top) begin
         out_min_ff <= out_rd_data.rmin;
         out_max_ff <= out_rd_data.rmax;
      end
      if (ctl.report && rsp_free) begin
         rsp_popped_ff <= PORT_W'(popped_ff);
         rsp_min_ff    <= q_empty ? '0 : PORT_W'(u_min);
         rsp_max_ff    <= q_empty ? '0 : PORT_W'(u_max);
         rsp_count_ff  <= COUNT_W'(total);
         rsp_status_ff <= status_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (ctl.report && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_queue_min    = rsp_min_ff;
   assign rsp_queue_max    = rsp_max_ff;
   assign rsp_item_count   = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> design/mmq_check.sv
// Port-level checks for the min/max queue, bound to the top level.
module mmq_check (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_popped_value,
   input logic signed [31:0] rsp_queue_min,
   input logic signed [31:0] rsp_queue_max,
   input logic [6:0]         rsp_item_count,
   input logic [1:0]         rsp_status
);
   import mmq_pkg::*;

   // Underflow reports an empty queue and nothing popped.
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNDERFLOW) |->
         (rsp_item_count == '0) && (rsp_popped_value == '0))
      else $error("underflow result not empty");

   // An empty queue reports zero extremes.
   a_empty_extremes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item_count == '0) |->
         (rsp_queue_min == '0) && (rsp_queue_max == '0))
      else $error("empty queue with nonzero extremes");

   // Extremes are ordered and the count stays within capacity.
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_min <= rsp_queue_max) &&
         (rsp_item_count <= 7'(DEPTH)))
      else $error("bad extremes or count");

   // Hold a stalled result.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_queue_min) &&
         $stable(rsp_item_count))
      else $error("stalled result changed");

endmodule

bind min_max_queue_two_stacks mmq_check u_mmq_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_popped_value (rsp_popped_value),
   .rsp_queue_min    (rsp_queue_min),
   .rsp_queue_max    (rsp_queue_max),
   .rsp_item_count   (rsp_item_count),
   .rsp_status       (rsp_status)
);
